// File: hdl/miu_pkg.sv
// package for the modular inverse unit: word width, coefficient width,
// counter width and the sequencer state type
// no dependencies
package miu_pkg;

    localparam int WORD_BITS = 32;
    // coefficients stay within +/- 2 * modulus, kept in two's complement
    localparam int CO_BITS   = WORD_BITS + 2;
    localparam int CNT_BITS  = $clog2(WORD_BITS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_UPD,
        ST_FIX1,
        ST_FIX2
    } state_t;

endpackage

// File: hdl/modular_inverse_unit_top.sv
// modular inverse by the extended euclidean algorithm, one quotient bit per cycle
// depends on miu_pkg
//
// usage:
//   s_axis carries one request: value in tdata[31:0], modulus in tdata[63:32].
//   m_axis returns one result per request: the inverse in tdata[31:0], taken
//   into 0 .. modulus-1. no coprimality check is made; a non-coprime pair gives
//   the reduced bezout coefficient. modulus zero gives zero.
//   each euclid round is a restoring division of the older remainder by the
//   newer one, producing one quotient bit per cycle over all WORD_BITS
//   dividend bits, while the coefficient product is built up msb first in the
//   same cycles; an update step (ST_UPD) then updates both pairs. after the
//   last round, ST_FIX1 and ST_FIX2 reduce the result into the output register.
//   one request is in work at a time, as all rounds share one divide loop; the
//   next request is taken once the sequencer is back in idle.
//   s_axis_tready is high only while the sequencer is idle. the result sits in
//   an output register, so a new request is taken while it waits; a finished
//   request waits in its last step until that register is free.
//   reset (rst_n low, asynchronous) returns the sequencer to idle and drops
//   m_axis_tvalid; nothing else needs clearing.
module modular_inverse_unit_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [2*miu_pkg::WORD_BITS-1:0] s_axis_tdata,  // value, modulus
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [miu_pkg::WORD_BITS-1:0] m_axis_tdata    // inverse
);

    localparam int W  = miu_pkg::WORD_BITS;
    localparam int CW = miu_pkg::CO_BITS;
    localparam int NB = miu_pkg::CNT_BITS;

    miu_pkg::state_t state_reg, state_next;

    logic [W-1:0]         rem_new_reg, rem_new_next;
    logic [W-1:0]         dvd_reg, dvd_next;
    logic [W-1:0]         p_reg, p_next;
    logic signed [CW-1:0] t_reg, t_next;
    logic signed [CW-1:0] co_old_reg, co_old_next;
    logic signed [CW-1:0] co_new_reg, co_new_next;
    logic [W-1:0]         mod_reg, mod_next;
    logic [NB-1:0]        cnt_reg, cnt_next;
    logic                 out_valid_reg, out_valid_next;
    logic [W-1:0]         out_data_reg, out_data_next;

    logic                 in_acc;
    logic                 out_free;
    logic [W:0]           trial;
    logic [W:0]           diff;
    logic                 qbit;
    logic signed [CW-1:0] mod_ext;
    logic signed [CW-1:0] red;

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign mod_ext  = $signed({2'b00, mod_reg});

    // restoring division step: bring down the next dividend bit
    assign trial = {p_reg, dvd_reg[W-1]};
    assign diff  = trial - {1'b0, rem_new_reg};
    assign qbit  = !diff[W];

    // final step of the reduction into 0 .. modulus-1
    assign red = (co_old_reg >= mod_ext) ? (co_old_reg - mod_ext) : co_old_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            miu_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = (s_axis_tdata[2*W-1:W] == '0) ? miu_pkg::ST_FIX1
                                                               : miu_pkg::ST_DIV;
                end
            end
            miu_pkg::ST_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = miu_pkg::ST_UPD;
                end
            end
            miu_pkg::ST_UPD:
            begin
                state_next = (p_reg == '0) ? miu_pkg::ST_FIX1 : miu_pkg::ST_DIV;
            end
            miu_pkg::ST_FIX1:
            begin
                state_next = miu_pkg::ST_FIX2;
            end
            miu_pkg::ST_FIX2:
            begin
                if (out_free)
                begin
                    state_next = miu_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = miu_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        rem_new_next   = rem_new_reg;
        dvd_next       = dvd_reg;
        p_next         = p_reg;
        t_next         = t_reg;
        co_old_next    = co_old_reg;
        co_new_next    = co_new_reg;
        mod_next       = mod_reg;
        cnt_next       = cnt_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        s_axis_tready  = 1'b0;
        unique case (state_reg)
            miu_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    rem_new_next = s_axis_tdata[2*W-1:W];
                    mod_next     = s_axis_tdata[2*W-1:W];
                    dvd_next     = s_axis_tdata[W-1:0];
                    co_old_next  = CW'(1);
                    co_new_next  = '0;
                    p_next       = '0;
                    t_next       = '0;
                    cnt_next     = NB'(W - 1);
                end
            end
            miu_pkg::ST_DIV:
            begin
                dvd_next = {dvd_reg[W-2:0], 1'b0};
                p_next   = qbit ? diff[W-1:0] : trial[W-1:0];
                // horner form of co_new * quotient, msb first
                t_next   = qbit ? ((t_reg <<< 1) + co_new_reg) : (t_reg <<< 1);
                cnt_next = cnt_reg - NB'(1);
            end
            miu_pkg::ST_UPD:
            begin
                rem_new_next = p_reg;
                co_old_next  = co_new_reg;
                co_new_next  = co_old_reg - t_reg;
                dvd_next     = rem_new_reg;
                p_next       = '0;
                t_next       = '0;
                cnt_next     = NB'(W - 1);
            end
            miu_pkg::ST_FIX1:
            begin
                if (co_old_reg < 0)
                begin
                    co_old_next = co_old_reg + mod_ext;
                end
            end
            miu_pkg::ST_FIX2:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = (mod_reg == '0) ? '0 : red[W-1:0];
                end
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= miu_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_new_reg  <= rem_new_next;
        dvd_reg      <= dvd_next;
        p_reg        <= p_next;
        t_reg        <= t_next;
        co_old_reg   <= co_old_next;
        co_new_reg   <= co_new_next;
        mod_reg      <= mod_next;
        cnt_reg      <= cnt_next;
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // the divisor is never zero while dividing
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == miu_pkg::ST_DIV) |-> (rem_new_reg != '0))
        else $error("division started with zero divisor");

    // partial remainder stays below the divisor
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == miu_pkg::ST_DIV) |-> (p_reg < rem_new_reg))
        else $error("partial remainder out of range");

    // a fresh result lies below its modulus
    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == miu_pkg::ST_FIX2 && out_free && mod_reg != '0)
            |=> (m_axis_tdata < $past(mod_reg)))
        else $error("result not reduced");

endmodule

// File: tb/modular_inverse_unit_top_test.sv
// testbench for the modular inverse unit: directed and random requests through
// the stream ports, results checked against an extended euclid predictor
// depends on miu_pkg and modular_inverse_unit_top
`timescale 1ns / 1ps

module modular_inverse_unit_top_test;

    localparam int W              = miu_pkg::WORD_BITS;
    localparam int RESET_CYCLES   = 6;
    localparam int SETTLE_CYCLES  = 1600;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [W-1:0] modulus;
        logic [W-1:0] value;
    } inv_req_t;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           s_valid = 1'b0;
    logic [2*W-1:0] s_data = '0;
    logic           m_ready = 1'b0;
    logic           s_axis_tready;
    logic           m_axis_tvalid;
    logic [W-1:0]   m_axis_tdata;

    inv_req_t       request_q[$];
    logic [W-1:0]   inverse_q[$];
    inv_req_t       next_req;
    logic           req_taken = 1'b0;
    logic           calm = 1'b0;
    int             send_gap = 0;
    int             recv_gap = 0;
    int             stall_cycles = 0;
    int             requests_sent = 0;
    int             results_checked = 0;
    int             mismatches = 0;
    int             shared_factor = 0;

    modular_inverse_unit_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_data),        // value, modulus
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_axis_tdata)   // inverse
    );

    always #6 clk = ~clk;

    // extended euclid on 64-bit two's complement coefficients
    function automatic logic [W-1:0] expected_inverse(logic [W-1:0] value,
                                                       logic [W-1:0] modulus);
        logic [63:0] rem_a;
        logic [63:0] rem_b;
        logic [63:0] co_a;
        logic [63:0] co_b;
        logic [63:0] quo;
        logic [63:0] rem_n;
        logic [63:0] co_n;
        logic [63:0] mag;
        rem_a = 64'(value);
        rem_b = 64'(modulus);
        co_a  = 64'd1;
        co_b  = 64'd0;
        if (modulus == '0)
            return '0;
        while (rem_b != 64'd0)
        begin
            quo   = rem_a / rem_b;
            rem_n = rem_a - rem_b * quo;
            co_n  = co_a - co_b * quo;
            rem_a = rem_b;
            rem_b = rem_n;
            co_a  = co_b;
            co_b  = co_n;
        end
        if (co_a[63])
        begin
            mag = (64'd0 - co_a) % 64'(modulus);
            return (mag == 64'd0) ? '0 : W'(64'(modulus) - mag);
        end
        return W'(co_a % 64'(modulus));
    endfunction

    function automatic logic [W-1:0] gcd_of(logic [W-1:0] a, logic [W-1:0] b);
        logic [W-1:0] t;
        while (b != '0)
        begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    task automatic report_mismatch(string what, logic [W-1:0] got, logic [W-1:0] want);
        $display("mismatch at %0t: %s, got %h expected %h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic push_request(logic [W-1:0] value, logic [W-1:0] modulus);
        inv_req_t r;
        r.value   = value;
        r.modulus = modulus;
        if (gcd_of(value, modulus) != 1)
            shared_factor++;
        request_q.push_back(r);
    endtask

    // sender holds off until every outstanding result is back
    task automatic wait_drain();
        while (request_q.size() > 0 || s_valid || inverse_q.size() > 0)
            @(posedge clk);
    endtask

    task automatic push_random(int count);
        logic [W-1:0] v;
        logic [W-1:0] m;
        logic [W-1:0] g;
        logic [W-1:0] fa;
        logic [W-1:0] fb;
        logic [W-1:0] ft;
        int           n;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    v = $urandom;
                    m = $urandom;
                end
                3:
                begin
                    // small modulus, any value
                    v = $urandom;
                    m = $urandom_range(1, 255);
                end
                4:
                begin
                    // odd modulus, value below it
                    m = $urandom | 1;
                    v = $urandom % m;
                end
                5:
                begin
                    // shared factor, not invertible
                    g = $urandom_range(2, 1000);
                    v = g * $urandom_range(0, 4000000);
                    m = g * $urandom_range(1, 4000000);
                end
                6:
                begin
                    // value at or above the modulus
                    m = $urandom >> $urandom_range(1, 31);
                    v = $urandom | m;
                end
                7:
                begin
                    // neighbouring fibonacci numbers give the longest runs
                    n  = $urandom_range(2, 45);
                    fa = 1;
                    fb = 1;
                    for (int k = 0; k < n; k++)
                    begin
                        ft = fa + fb;
                        fa = fb;
                        fb = ft;
                    end
                    v = fa;
                    m = fb;
                    if ($urandom_range(0, 1) == 1)
                    begin
                        v = fb;
                        m = fa;
                    end
                end
                8:
                begin
                    v = $urandom >> $urandom_range(0, 31);
                    m = $urandom >> $urandom_range(0, 31);
                end
                default:
                begin
                    v = $urandom_range(0, 3) == 0 ? '1 : $urandom;
                    m = $urandom_range(0, 1) == 0 ? '1 : ($urandom_range(0, 1) ? 1 : 2);
                end
            endcase
            if (m == '0)
                m = 1;
            push_request(v, m);
        end
    endtask

    // driver: new request at the falling edge once the previous one was taken
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_valid <= 1'b0;
        end
        else if (!s_valid || req_taken)
        begin
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                s_valid  <= 1'b0;
            end
            else if (request_q.size() > 0)
            begin
                next_req = request_q.pop_front();
                s_data  <= {next_req.modulus, next_req.value};
                s_valid <= 1'b1;
                if (!calm && $urandom_range(0, 5) == 0)
                    send_gap <= $urandom_range(1, 13);
            end
            else
            begin
                s_valid <= 1'b0;
            end
        end
    end

    // result side back-pressure
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_ready <= 1'b0;
        end
        else if (recv_gap > 0)
        begin
            recv_gap <= recv_gap - 1;
            m_ready  <= 1'b0;
        end
        else
        begin
            m_ready <= 1'b1;
            if (!calm && $urandom_range(0, 3) == 0)
                recv_gap <= $urandom_range(1, 13);
        end
    end

    // monitor: predict on request, compare on result
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_taken <= 1'b0;
        end
        else
        begin
            req_taken <= s_valid && s_axis_tready;
            if (s_valid && s_axis_tready)
            begin
                inverse_q.push_back(expected_inverse(s_data[W-1:0], s_data[2*W-1:W]));
                requests_sent <= requests_sent + 1;
            end
            if (m_axis_tvalid && m_ready)
            begin
                if (inverse_q.size() == 0)
                    report_mismatch("result with no request outstanding", m_axis_tdata, '0);
                else if (m_axis_tdata !== inverse_q[0])
                    report_mismatch("inverse", m_axis_tdata, inverse_q.pop_front());
                else
                    void'(inverse_q.pop_front());
                results_checked <= results_checked + 1;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_valid && s_axis_tready) || (m_axis_tvalid && m_ready) || !rst_n)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == WATCHDOG_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        push_request(32'h0000_0000, 32'h0000_0007);   // value zero
        push_request(32'h0000_0005, 32'h0000_0001);   // modulus one
        push_request(32'h0000_0000, 32'h0000_0001);
        push_request(32'h0000_0003, 32'h0000_0007);
        push_request(32'h0000_000a, 32'h0000_0007);   // value above modulus
        push_request(32'h0000_0007, 32'h0000_0007);
        push_request(32'h0000_0006, 32'h0000_0009);   // shared factor
        push_request(32'hffff_ffff, 32'hffff_ffff);
        push_request(32'hffff_ffff, 32'hffff_fffe);
        push_request(32'hffff_fffe, 32'hffff_ffff);
        push_request(32'h0000_0001, 32'hffff_ffff);
        push_request(32'h0000_0000, 32'hffff_ffff);
        push_request(32'hffff_ffff, 32'h0000_0001);
        push_request(32'd1836311903, 32'd2971215073); // longest euclid chain
        push_request(32'd2971215073, 32'd1836311903);
        push_request(32'h0000_0002, 32'h8000_0000);
        push_request(32'h8000_0000, 32'h8000_0001);
        push_request(32'haaaa_aaaa, 32'h5555_5555);
        push_request(32'h5555_5555, 32'haaaa_aaab);
        push_request(32'd12345, 32'd65537);
        push_request(32'h0000_0001, 32'h0000_0002);
        wait_drain();

        push_random(180);
        wait_drain();
        push_random(130);
        wait_drain();
        calm = 1'b1;
        push_random(60);
        wait_drain();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (inverse_q.size() != 0)
            report_mismatch("results never returned", W'(inverse_q.size()), '0);
        $display("%0d requests sent, %0d results checked, %0d with a shared factor",
                 requests_sent, results_checked, shared_factor);
        $display("covered zero value, unit modulus, full-width words and long euclid chains");
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
